@@ design/bcim_pkg.sv @@
// Shared types, register codes and helper functions of the block-cyclic index map.
`timescale 1ns / 1ps

package bcim_pkg;

	// Width and range limits.
	localparam int COORD_W = 16;
	localparam int PROC_W = 12;
	localparam int BLK_W = 17;
	localparam int NPROC_W = 13;
	localparam int WIDE_W = 52;
	localparam int MAX_DIM = 65536;
	localparam int MAX_PROCS = 4096;

	// Each axis divides twice, one quotient bit per cell.
	localparam int DIV_CELLS = 2 * COORD_W;
	// Cells, two multiply stages and the output register.
	localparam int PIPE_DEPTH = DIV_CELLS + 3;

	// Configuration register indexes.
	localparam logic [2:0] REG_BLOCK_ROWS = 3'd0;
	localparam logic [2:0] REG_BLOCK_COLS = 3'd1;
	localparam logic [2:0] REG_PROC_ROWS = 3'd2;
	localparam logic [2:0] REG_PROC_COLS = 3'd3;
	localparam logic [2:0] REG_MATRIX_ROWS = 3'd4;
	localparam logic [2:0] REG_MATRIX_COLS = 3'd5;

	// Operation codes.
	localparam logic OP_TO_LOCAL = 1'b0;
	localparam logic OP_TO_GLOBAL = 1'b1;

	// Partial state of one restoring division.
	typedef struct packed {
		logic [BLK_W-1:0] rem;
		logic [COORD_W-1:0] num;
	} div_t;

	// Result of one axis after the multiply stages.
	typedef struct packed {
		logic [WIDE_W-1:0] val;
		logic [PROC_W-1:0] own;
	} axis_res_t;

	// Block size as used: zero counts as one, large values saturate.
	function automatic logic [BLK_W-1:0] eff_block(input logic [BLK_W-1:0] v);
		logic [BLK_W-1:0] r;
		r = v;
		if (v == '0) r = BLK_W'(1);
		else if (v > BLK_W'(MAX_DIM)) r = BLK_W'(MAX_DIM);
		return r;
	endfunction

	// Process count as used: zero counts as one, large values saturate.
	function automatic logic [NPROC_W-1:0] eff_procs(input logic [NPROC_W-1:0] v);
		logic [NPROC_W-1:0] r;
		r = v;
		if (v == '0) r = NPROC_W'(1);
		else if (v > NPROC_W'(MAX_PROCS)) r = NPROC_W'(MAX_PROCS);
		return r;
	endfunction

endpackage

@@ design/bcim_div_cell.sv @@
// One restoring division step, registered.
`timescale 1ns / 1ps

module bcim_div_cell import bcim_pkg::*; (
	input  logic             clk,
	input  div_t             d_in,
	input  logic [BLK_W-1:0] divisor,
	output div_t             d_out
);

	logic [BLK_W:0] trial;
	logic           fits;

	// Shift the next dividend bit into the partial remainder and try to subtract.
	assign trial = {d_in.rem, d_in.num[COORD_W-1]};
	assign fits = trial >= {1'b0, divisor};

	always_ff @(posedge clk) begin
		if (fits) begin
			d_out.rem <= BLK_W'(trial - {1'b0, divisor});
		end else begin
			d_out.rem <= trial[BLK_W-1:0];
		end
		d_out.num <= {d_in.num[COORD_W-2:0], fits};
	end

endmodule

@@ design/bcim_axis.sv @@
// Index translation along one axis: a chain of division cells, then two multiply stages.
`timescale 1ns / 1ps

module bcim_axis import bcim_pkg::*; (
	input  logic               clk,
	input  logic               op,
	input  logic [COORD_W-1:0] coord,
	input  logic [PROC_W-1:0]  proc_coord,
	input  logic [BLK_W-1:0]   blk,
	input  logic [NPROC_W-1:0] nproc,
	output axis_res_t          res
);

	div_t               st [DIV_CELLS+1];
	div_t               cin [DIV_CELLS];
	logic               op_q [DIV_CELLS];
	logic [PROC_W-1:0]  pc_q [DIV_CELLS];
	logic [COORD_W-1:0] r1_q [COORD_W];
	logic [COORD_W-1:0] q1_q [COORD_W];

	logic [BLK_W-1:0]   mul_b;
	logic [COORD_W-1:0] mul_a;
	logic [BLK_W+COORD_W-1:0] prod;

	logic               op_s1;
	logic [PROC_W-1:0]  pc_s1;
	logic [COORD_W-1:0] r1_s1;
	logic [PROC_W-1:0]  r2_s1;
	logic [BLK_W+COORD_W:0] t_s1;

	assign st[0] = '{rem: '0, num: coord};

	// First half divides the coordinate by the block size, second half the block index
	// by the process count.
	for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
		if (i == COORD_W) begin : g_restart
			assign cin[i] = '{rem: '0, num: st[i].num};
		end else begin : g_pass
			assign cin[i] = st[i];
		end
		bcim_div_cell u_cell (
			.clk    (clk),
			.d_in   (cin[i]),
			.divisor((i < COORD_W) ? blk : BLK_W'(nproc)),
			.d_out  (st[i+1])
		);
		always_ff @(posedge clk) begin
			op_q[i] <= (i == 0) ? op : op_q[(i == 0) ? 0 : i-1];
			pc_q[i] <= (i == 0) ? proc_coord : pc_q[(i == 0) ? 0 : i-1];
		end
	end

	// Offset and block index of the first division travel beside the second one.
	for (genvar j = 0; j < COORD_W; j++) begin : g_side
		always_ff @(posedge clk) begin
			if (j == 0) begin
				r1_q[j] <= st[COORD_W].rem[COORD_W-1:0];
				q1_q[j] <= st[COORD_W].num;
			end else begin
				r1_q[j] <= r1_q[(j == 0) ? 0 : j-1];
				q1_q[j] <= q1_q[(j == 0) ? 0 : j-1];
			end
		end
	end

	// First multiply: local block times block size, or block index times process count.
	assign mul_a = (op_q[DIV_CELLS-1] == OP_TO_GLOBAL) ? q1_q[COORD_W-1]
		: st[DIV_CELLS].num;
	assign mul_b = (op_q[DIV_CELLS-1] == OP_TO_GLOBAL) ? BLK_W'(nproc) : blk;
	assign prod = (BLK_W+COORD_W)'(mul_a) * (BLK_W+COORD_W)'(mul_b);

	always_ff @(posedge clk) begin
		op_s1 <= op_q[DIV_CELLS-1];
		pc_s1 <= pc_q[DIV_CELLS-1];
		r1_s1 <= r1_q[COORD_W-1];
		r2_s1 <= st[DIV_CELLS].rem[PROC_W-1:0];
		if (op_q[DIV_CELLS-1] == OP_TO_GLOBAL) begin
			t_s1 <= {1'b0, prod} + (BLK_W+COORD_W+1)'(pc_q[DIV_CELLS-1]);
		end else begin
			t_s1 <= {1'b0, prod};
		end
	end

	// Second multiply scales the global block back to elements in the to-global case; add the offset.
	always_ff @(posedge clk) begin
		if (op_s1 == OP_TO_GLOBAL) begin
			res.val <= WIDE_W'(WIDE_W'(t_s1) * WIDE_W'(blk)) + WIDE_W'(r1_s1);
			res.own <= pc_s1;
		end else begin
			res.val <= WIDE_W'(t_s1) + WIDE_W'(r1_s1);
			res.own <= r2_s1;
		end
	end

endmodule

@@ design/block_cyclic_index_map.sv @@
// Top level of the block-cyclic index map: configuration registers, two axis lanes, output.
`timescale 1ns / 1ps

// Translates one coordinate pair per clock between global and local numbering under a
// 2D block-cyclic layout. busy stays low, so a new transaction may start in every cycle;
// each result appears on done for one cycle once it has passed through the chain of
// 32 one-bit division cells per axis, two multiply stages and the output register.
// Results cannot be held off. Configuration writes are always ready and must
// only be issued while no transaction is in flight.
module block_cyclic_index_map import bcim_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               operation,
	input  logic [COORD_W-1:0] in_row,
	input  logic [COORD_W-1:0] in_col,
	input  logic [PROC_W-1:0]  in_proc_row,
	input  logic [PROC_W-1:0]  in_proc_col,
	output logic               done,
	output logic [COORD_W-1:0] out_row,
	output logic [COORD_W-1:0] out_col,
	output logic [PROC_W-1:0]  owner_row,
	output logic [PROC_W-1:0]  owner_col,
	output logic               in_range,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [BLK_W-1:0]   cfg_data
);

	logic [BLK_W-1:0]   block_rows_q, block_cols_q, matrix_rows_q, matrix_cols_q;
	logic [NPROC_W-1:0] proc_rows_q, proc_cols_q;
	logic [PIPE_DEPTH-2:0] vld_q;
	logic [PIPE_DEPTH-2:0] op_q;
	axis_res_t res_r, res_c;
	logic fit_r, fit_c;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_rows_q <= BLK_W'(64);
			block_cols_q <= BLK_W'(64);
			proc_rows_q <= NPROC_W'(1);
			proc_cols_q <= NPROC_W'(1);
			matrix_rows_q <= BLK_W'(MAX_DIM);
			matrix_cols_q <= BLK_W'(MAX_DIM);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BLOCK_ROWS: block_rows_q <= cfg_data;
				REG_BLOCK_COLS: block_cols_q <= cfg_data;
				REG_PROC_ROWS: proc_rows_q <= cfg_data[NPROC_W-1:0];
				REG_PROC_COLS: proc_cols_q <= cfg_data[NPROC_W-1:0];
				REG_MATRIX_ROWS: matrix_rows_q <= cfg_data;
				REG_MATRIX_COLS: matrix_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Transaction valid and operation travel beside the lanes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[PIPE_DEPTH-3:0], start && !busy};
		end
	end

	always_ff @(posedge clk) begin
		op_q <= {op_q[PIPE_DEPTH-3:0], operation};
	end

	// One lane per axis.
	bcim_axis u_row (
		.clk       (clk),
		.op        (operation),
		.coord     (in_row),
		.proc_coord(in_proc_row),
		.blk       (eff_block(block_rows_q)),
		.nproc     (eff_procs(proc_rows_q)),
		.res       (res_r)
	);

	bcim_axis u_col (
		.clk       (clk),
		.op        (operation),
		.coord     (in_col),
		.proc_coord(in_proc_col),
		.blk       (eff_block(block_cols_q)),
		.nproc     (eff_procs(proc_cols_q)),
		.res       (res_c)
	);

	// Range check of a global result against the matrix and the coordinate width.
	assign fit_r = (res_r.val < WIDE_W'(matrix_rows_q)) && (res_r.val < WIDE_W'(MAX_DIM));
	assign fit_c = (res_c.val < WIDE_W'(matrix_cols_q)) && (res_c.val < WIDE_W'(MAX_DIM));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_q[PIPE_DEPTH-2];
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		owner_row <= res_r.own;
		owner_col <= res_c.own;
		if (op_q[PIPE_DEPTH-2] == OP_TO_GLOBAL && !(fit_r && fit_c)) begin
			out_row <= '0;
			out_col <= '0;
			in_range <= 1'b0;
		end else begin
			out_row <= res_r.val[COORD_W-1:0];
			out_col <= res_c.val[COORD_W-1:0];
			in_range <= 1'b1;
		end
	end

`ifndef SYNTHESIS
	// Every accepted transaction yields exactly one result on done.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##PIPE_DEPTH done)
		else $error("result missing after start");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_DEPTH))
		else $error("result without a started transaction");
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !in_range |-> out_row == '0 && out_col == '0)
		else $error("out of range result has nonzero coordinates");
`endif

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the block-cyclic index map.
`timescale 1ns / 1ps

module testbench;
	import bcim_pkg::*;

	typedef struct {
		logic               op;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [PROC_W-1:0]  prow;
		logic [PROC_W-1:0]  pcol;
	} coord_req_t;

	typedef struct {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [PROC_W-1:0]  own_r;
		logic [PROC_W-1:0]  own_c;
		logic               ok;
	} coord_map_t;

	localparam int CYCLE_LIMIT = 400000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               operation = 1'b0;
	logic [COORD_W-1:0] in_row = '0;
	logic [COORD_W-1:0] in_col = '0;
	logic [PROC_W-1:0]  in_proc_row = '0;
	logic [PROC_W-1:0]  in_proc_col = '0;
	logic               done;
	logic [COORD_W-1:0] out_row;
	logic [COORD_W-1:0] out_col;
	logic [PROC_W-1:0]  owner_row;
	logic [PROC_W-1:0]  owner_col;
	logic               in_range;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [BLK_W-1:0]   cfg_data = '0;

	// Local copy of the layout registers.
	logic [BLK_W-1:0]   lay_block_rows = 17'd64;
	logic [BLK_W-1:0]   lay_block_cols = 17'd64;
	logic [NPROC_W-1:0] lay_proc_rows = 13'd1;
	logic [NPROC_W-1:0] lay_proc_cols = 13'd1;
	logic [BLK_W-1:0]   lay_matrix_rows = 17'd65536;
	logic [BLK_W-1:0]   lay_matrix_cols = 17'd65536;

	coord_map_t pending_maps[$];
	int         error_count = 0;
	int         cycle_count = 0;

	block_cyclic_index_map dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .in_row(in_row), .in_col(in_col),
		.in_proc_row(in_proc_row), .in_proc_col(in_proc_col),
		.done(done), .out_row(out_row), .out_col(out_col),
		.owner_row(owner_row), .owner_col(owner_col), .in_range(in_range),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// Block size and process count as the block uses them.
	function automatic longint unsigned used_block(logic [BLK_W-1:0] v);
		if (v == 0) return 1;
		if (v > MAX_DIM) return MAX_DIM;
		return v;
	endfunction

	function automatic longint unsigned used_procs(logic [NPROC_W-1:0] v);
		if (v == 0) return 1;
		if (v > MAX_PROCS) return MAX_PROCS;
		return v;
	endfunction

	// Expected translation of one request under the current layout.
	function automatic coord_map_t map_coords(coord_req_t q);
		coord_map_t m;
		longint unsigned br, bc, npr, npc, blk_r, blk_c, gi, gj;
		br = used_block(lay_block_rows);
		bc = used_block(lay_block_cols);
		npr = used_procs(lay_proc_rows);
		npc = used_procs(lay_proc_cols);
		if (q.op == OP_TO_LOCAL) begin
			blk_r = q.row / br;
			blk_c = q.col / bc;
			m.row = COORD_W'((blk_r / npr) * br + q.row % br);
			m.col = COORD_W'((blk_c / npc) * bc + q.col % bc);
			m.own_r = PROC_W'(blk_r % npr);
			m.own_c = PROC_W'(blk_c % npc);
			m.ok = 1'b1;
		end else begin
			gi = ((q.row / br) * npr + q.prow) * br + q.row % br;
			gj = ((q.col / bc) * npc + q.pcol) * bc + q.col % bc;
			m.own_r = q.prow;
			m.own_c = q.pcol;
			if (gi >= lay_matrix_rows || gj >= lay_matrix_cols ||
					gi >= MAX_DIM || gj >= MAX_DIM) begin
				m.row = '0;
				m.col = '0;
				m.ok = 1'b0;
			end else begin
				m.row = COORD_W'(gi);
				m.col = COORD_W'(gj);
				m.ok = 1'b1;
			end
		end
		return m;
	endfunction

	// Compare each result with the oldest expected translation.
	always @(posedge clk) begin
		coord_map_t e;
		if (arst_n && done) begin
			if (pending_maps.size() == 0) begin
				$error("unexpected result transaction");
				error_count++;
			end else begin
				e = pending_maps.pop_front();
				if (out_row !== e.row) begin
					$error("out_row: expected %0d, got %0d", e.row, out_row);
					error_count++;
				end
				if (out_col !== e.col) begin
					$error("out_col: expected %0d, got %0d", e.col, out_col);
					error_count++;
				end
				if (owner_row !== e.own_r) begin
					$error("owner_row: expected %0d, got %0d", e.own_r, owner_row);
					error_count++;
				end
				if (owner_col !== e.own_c) begin
					$error("owner_col: expected %0d, got %0d", e.own_c, owner_col);
					error_count++;
				end
				if (in_range !== e.ok) begin
					$error("in_range: expected %0d, got %0d", e.ok, in_range);
					error_count++;
				end
			end
		end
	end

	// Issue one request and record its expected translation on acceptance.
	task automatic send_coord(coord_req_t q);
		@(negedge clk);
		start <= 1'b1;
		operation <= q.op;
		in_row <= q.row;
		in_col <= q.col;
		in_proc_row <= q.prow;
		in_proc_col <= q.pcol;
		do @(posedge clk); while (busy);
		pending_maps.push_back(map_coords(q));
	endtask

	// Random sender gap: mostly none, sometimes short, rarely long.
	task automatic sender_gap();
		int n;
		n = $urandom_range(0, 9);
		if (n < 6) return;
		n = (n == 9) ? $urandom_range(20, 60) : $urandom_range(1, 3);
		@(negedge clk);
		start <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// Stop sending and wait until every expected result has arrived.
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_maps.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	// Write one layout register; the pipeline must be empty.
	task automatic write_reg(logic [2:0] idx, logic [BLK_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_BLOCK_ROWS:  lay_block_rows = val;
			REG_BLOCK_COLS:  lay_block_cols = val;
			REG_PROC_ROWS:   lay_proc_rows = val[NPROC_W-1:0];
			REG_PROC_COLS:   lay_proc_cols = val[NPROC_W-1:0];
			REG_MATRIX_ROWS: lay_matrix_rows = val;
			REG_MATRIX_COLS: lay_matrix_cols = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_layout(logic [BLK_W-1:0] br, logic [BLK_W-1:0] bc,
			logic [BLK_W-1:0] pr, logic [BLK_W-1:0] pc,
			logic [BLK_W-1:0] mr, logic [BLK_W-1:0] mc);
		drain();
		write_reg(REG_BLOCK_ROWS, br);
		write_reg(REG_BLOCK_COLS, bc);
		write_reg(REG_PROC_ROWS, pr);
		write_reg(REG_PROC_COLS, pc);
		write_reg(REG_MATRIX_ROWS, mr);
		write_reg(REG_MATRIX_COLS, mc);
	endtask

	function automatic coord_req_t make_req(logic op, int r, int c, int pr, int pc);
		coord_req_t q;
		q.op = op;
		q.row = COORD_W'(r);
		q.col = COORD_W'(c);
		q.prow = PROC_W'(pr);
		q.pcol = PROC_W'(pc);
		return q;
	endfunction

	// Field extremes under the reset layout.
	task automatic test_reset_layout();
		send_coord(make_req(OP_TO_LOCAL, 0, 0, 0, 0));
		send_coord(make_req(OP_TO_LOCAL, 65535, 65535, 4095, 4095));
		send_coord(make_req(OP_TO_GLOBAL, 0, 0, 0, 0));
		send_coord(make_req(OP_TO_GLOBAL, 65535, 65535, 0, 0));
		send_coord(make_req(OP_TO_GLOBAL, 100, 200, 4095, 4095));
	endtask

	// Zero and oversized block sizes and process counts.
	task automatic test_saturation();
		write_layout(17'd0, 17'd0, 17'd0, 17'd0, 17'd65536, 17'd65536);
		send_coord(make_req(OP_TO_LOCAL, 12345, 54321, 0, 0));
		send_coord(make_req(OP_TO_GLOBAL, 7, 9, 1, 2));
		write_layout(17'h1FFFF, 17'd65537, 17'h1FFF, 17'd4097, 17'd65536, 17'd65536);
		send_coord(make_req(OP_TO_LOCAL, 65535, 65535, 0, 0));
		send_coord(make_req(OP_TO_GLOBAL, 65535, 3, 4095, 0));
		write_layout(17'd65536, 17'd1, 17'd4096, 17'd4096, 17'h1FFFF, 17'h1FFFF);
		send_coord(make_req(OP_TO_LOCAL, 40000, 40000, 0, 0));
		send_coord(make_req(OP_TO_GLOBAL, 0, 15, 4095, 4095));
		send_coord(make_req(OP_TO_GLOBAL, 1, 16, 0, 0));
	endtask

	// Row and column range checks at their edges, and oversized process coordinates.
	task automatic test_range_edges();
		write_layout(17'd4, 17'd8, 17'd3, 17'd2, 17'd100, 17'd50);
		send_coord(make_req(OP_TO_GLOBAL, 33, 1, 0, 0));
		send_coord(make_req(OP_TO_GLOBAL, 32, 1, 0, 0));
		send_coord(make_req(OP_TO_GLOBAL, 1, 25, 0, 0));
		send_coord(make_req(OP_TO_GLOBAL, 1, 24, 1, 0));
		send_coord(make_req(OP_TO_GLOBAL, 1, 1, 4095, 2));
		send_coord(make_req(OP_TO_LOCAL, 65535, 65535, 0, 0));
		write_layout(17'd1, 17'd1, 17'd1, 17'd1, 17'd1, 17'd1);
		send_coord(make_req(OP_TO_GLOBAL, 0, 0, 0, 0));
		send_coord(make_req(OP_TO_GLOBAL, 0, 1, 0, 0));
		write_layout(17'd64, 17'd64, 17'd1, 17'd1, 17'd0, 17'd65536);
		send_coord(make_req(OP_TO_GLOBAL, 0, 0, 0, 0));
	endtask

	function automatic logic [BLK_W-1:0] pick_block();
		case ($urandom_range(0, 3))
			0: return BLK_W'($urandom_range(0, 8));
			1: return BLK_W'($urandom_range(1, 300));
			2: return BLK_W'($urandom_range(1, 65536));
			default: return BLK_W'($urandom);
		endcase
	endfunction

	function automatic logic [BLK_W-1:0] pick_procs();
		case ($urandom_range(0, 3))
			0: return BLK_W'($urandom_range(0, 4));
			1: return BLK_W'($urandom_range(1, 40));
			2: return BLK_W'($urandom_range(1, 4096));
			default: return BLK_W'($urandom);
		endcase
	endfunction

	function automatic logic [BLK_W-1:0] pick_extent();
		return ($urandom_range(0, 2) == 0) ? BLK_W'($urandom) :
			BLK_W'($urandom_range(1, 65536));
	endfunction

	// Random layouts, each followed by a burst of random requests.
	task automatic test_random_traffic(int phases, int per_phase);
		coord_req_t q;
		longint unsigned npr, npc, span_r, span_c;
		for (int p = 0; p < phases; p++) begin
			write_layout(pick_block(), pick_block(), pick_procs(), pick_procs(),
				pick_extent(), pick_extent());
			npr = used_procs(lay_proc_rows);
			npc = used_procs(lay_proc_cols);
			span_r = (lay_matrix_rows > 0) ? lay_matrix_rows / npr : 1;
			span_c = (lay_matrix_cols > 0) ? lay_matrix_cols / npc : 1;
			for (int i = 0; i < per_phase; i++) begin
				q.op = logic'($urandom_range(0, 1));
				q.row = COORD_W'($urandom);
				q.col = COORD_W'($urandom);
				q.prow = PROC_W'($urandom);
				q.pcol = PROC_W'($urandom);
				// Mostly requests that land inside the matrix.
				if (q.op == OP_TO_GLOBAL && $urandom_range(0, 3) != 0) begin
					q.row = COORD_W'($urandom % (span_r + 1));
					q.col = COORD_W'($urandom % (span_c + 1));
					q.prow = PROC_W'($urandom % npr);
					q.pcol = PROC_W'($urandom % npc);
				end
				send_coord(q);
				if (p % 3 != 1) sender_gap();
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_layout();
		test_saturation();
		test_range_edges();
		test_random_traffic(9, 105);
		drain();
		if (error_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
